// ===== rtl/bichc_pkg.sv =====
// ----------------------------------------------------------------------------
// bichc_pkg: shared types and constants for the boot image checker
// Beat kinds, verdict codes, header constants and the byte-wide CRC-32 step.
// ----------------------------------------------------------------------------
package bichc_pkg;

   localparam logic [31:0] CRC_POLY      = 32'hedb8_8320;
   localparam logic [31:0] CRC_ONES      = 32'hffff_ffff;
   localparam logic [31:0] IMG_MAGIC     = 32'h434f_4758;
   localparam logic [15:0] IMG_VERSION   = 16'd1;
   localparam logic [15:0] IMG_HDR_SIZE  = 16'd32;
   localparam logic [4:0]  HDR_CRC_SPAN  = 5'd28;
   localparam logic [4:0]  HDR_LAST_POS  = 5'd31;
   localparam logic [31:0] LOAD_RESET    = 32'h8700_0000;
   localparam logic [31:0] LIMIT_RESET   = 32'h00cd_ae00;

   // register map index (byte address bit 2)
   localparam logic REG_LOAD  = 1'b0;
   localparam logic REG_LIMIT = 1'b1;

   typedef enum logic {
      KIND_DATA = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } item_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_SHORT_HDR  = 3'd1,
      ST_BAD_HDR    = 3'd2,
      ST_BAD_LAYOUT = 3'd3,
      ST_SHORT_PAY  = 3'd4,
      ST_PAY_CRC    = 3'd5
   } status_type;

   typedef enum logic {
      PH_HEADER  = 1'b0,
      PH_PAYLOAD = 1'b1
   } phase_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] entry;
      logic [31:0] plen;
      logic [31:0] clen;
   } verdict_type;

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] x;
      x = c ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         x = {1'b0, x[31:1]} ^ (CRC_POLY & {32{x[0]}});
      end
      return x;
   endfunction

endpackage

// ===== rtl/bichc_front.sv =====
// ----------------------------------------------------------------------------
// bichc_front: input side of the checker
// Tags each beat as data or end of file and parks it in a short queue.
// ----------------------------------------------------------------------------
module bichc_front import bichc_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic [0:0] req_tuser,   // [0] stream_ended
   output logic       q_valid,
   output item_type   q_item,
   input  logic       q_pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   item_type         beat;

   assign req_tready = (count_ff != CNT_FULL);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign q_item     = mem_ff[rd_ptr_ff];

   always_comb begin
      beat.kind = req_tuser[0] ? KIND_END : KIND_DATA;
      beat.data = req_tdata;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= beat;
      end
   end

endmodule

// ===== rtl/bichc_back.sv =====
// ----------------------------------------------------------------------------
// bichc_back: header parse, CRC-32 and verdict engine
// One beat per cycle while the verdict slot can take a result; header checks spread over the last four header bytes.
// ----------------------------------------------------------------------------
module bichc_back import bichc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   input  logic [31:0] exp_load,
   input  logic [31:0] size_limit,
   output logic        v_valid,
   output verdict_type v_data,
   input  logic        v_ready
);

   phase_type   phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] remain_ff, remain_in;
   logic [31:0] hw_ff [7];
   logic [31:0] hw_in [7];
   logic [31:0] end_ff, end_in;
   logic [31:0] ent_ff, ent_in;
   logic [31:0] clen_ff, clen_in;
   logic        id_ok_ff, id_ok_in;
   logic        lay_a_ff, lay_a_in;
   logic        lay_b_ff, lay_b_in;
   logic        fire;
   logic [31:0] crc_step;
   logic [31:0] crc_tail;

   assign fire  = q_valid && v_ready;
   assign q_pop = fire;

   assign crc_step = crc_byte(crc_ff, q_item.data);
   assign crc_tail = crc_ff ^ ({24'h0, q_item.data} << {pos_ff[1:0], 3'b000});

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      remain_in = remain_ff;
      hw_in     = hw_ff;
      end_in    = end_ff;
      ent_in    = ent_ff;
      clen_in   = clen_ff;
      id_ok_in  = id_ok_ff;
      lay_a_in  = lay_a_ff;
      lay_b_in  = lay_b_ff;
      v_valid   = 1'b0;
      v_data    = '{status: ST_OK, entry: '0, plen: '0, clen: '0};

      if (fire) begin
         case (phase_ff)
            PH_PAYLOAD: begin
               if (q_item.kind == KIND_END) begin
                  v_valid = 1'b1;
                  v_data  = '{status: ST_SHORT_PAY, entry: '0, plen: hw_ff[4],
                              clen: clen_ff};
               end else if (remain_ff == 32'd1) begin
                  v_valid = 1'b1;
                  if ((crc_step ^ CRC_ONES) == hw_ff[6]) begin
                     v_data = '{status: ST_OK, entry: ent_ff, plen: hw_ff[4],
                                clen: clen_ff};
                  end else begin
                     v_data = '{status: ST_PAY_CRC, entry: '0, plen: hw_ff[4],
                                clen: clen_ff};
                  end
               end else begin
                  crc_in    = crc_step;
                  remain_in = remain_ff - 32'd1;
               end
            end
            default: begin
               if (q_item.kind == KIND_END) begin
                  v_valid = 1'b1;
                  v_data  = '{status: ST_SHORT_HDR, entry: '0, plen: '0, clen: '0};
               end else begin
                  pos_in = pos_ff + 5'd1;
                  if (pos_ff < HDR_CRC_SPAN) begin
                     hw_in[pos_ff[4:2]][{pos_ff[1:0], 3'b000} +: 8] = q_item.data;
                     crc_in = crc_step;
                  end else begin
                     crc_in = crc_tail;
                  end
                  // layout work staged over bytes 28..31
                  case (pos_ff[1:0])
                     2'd0: begin
                        end_in   = hw_ff[2] + hw_ff[5];
                        ent_in   = hw_ff[2] + hw_ff[3];
                        id_ok_in = (hw_ff[0] == IMG_MAGIC) &&
                                   (hw_ff[1][15:0] == IMG_VERSION) &&
                                   (hw_ff[1][31:16] == IMG_HDR_SIZE);
                     end
                     2'd1: begin
                        lay_a_in = (hw_ff[4] == '0) || (hw_ff[5] < hw_ff[4]) ||
                                   (hw_ff[3] >= hw_ff[4]);
                        clen_in  = hw_ff[5] - hw_ff[4];
                     end
                     2'd2: begin
                        lay_b_in = (end_ff < hw_ff[2]) || (ent_ff < hw_ff[2]) ||
                                   (ent_ff >= end_ff);
                     end
                     default: begin
                     end
                  endcase
                  if (pos_ff == HDR_LAST_POS) begin
                     if (!id_ok_ff || (crc_tail != CRC_ONES)) begin
                        v_valid = 1'b1;
                        v_data  = '{status: ST_BAD_HDR, entry: '0, plen: '0, clen: '0};
                     end else if (lay_a_ff || lay_b_ff || (hw_ff[2] != exp_load) ||
                                  (hw_ff[5] > size_limit)) begin
                        v_valid = 1'b1;
                        v_data  = '{status: ST_BAD_LAYOUT, entry: '0, plen: '0,
                                    clen: '0};
                     end else begin
                        phase_in  = PH_PAYLOAD;
                        pos_in    = '0;
                        crc_in    = CRC_ONES;
                        remain_in = hw_ff[4];
                     end
                  end
               end
            end
         endcase
         // every verdict restarts the image
         if (v_valid) begin
            phase_in = PH_HEADER;
            pos_in   = '0;
            crc_in   = CRC_ONES;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         crc_ff   <= CRC_ONES;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      hw_ff     <= hw_in;
      end_ff    <= end_in;
      ent_ff    <= ent_in;
      clen_ff   <= clen_in;
      id_ok_ff  <= id_ok_in;
      lay_a_ff  <= lay_a_in;
      lay_b_ff  <= lay_b_in;
   end

endmodule

// ===== rtl/boot_image_header_and_crc_checker_core.sv =====
// ----------------------------------------------------------------------------
// boot_image_header_and_crc_checker_core: boot image header and CRC-32 checker
// Parses a 32-byte image header, checks id, header CRC and layout, then runs
// the payload through CRC-32 and reports one verdict per image.
// ----------------------------------------------------------------------------
// Throughput: one byte beat per cycle while the verdict slot is free or draining,
//   header and payload alike; the byte-wide CRC step in the back engine sets that figure.
// Path: an accepted beat waits in the queue slot, the engine works on it
//   combinationally, and its verdict is registered in the output register that
//   drives rsp_tvalid; a blocked verdict slot holds the beat in the queue.
// Reset: synchronous, active high; clears queue, phase, byte count and CRC,
//   loads both CSRs with their defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module boot_image_header_and_crc_checker_core import bichc_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   // byte stream in
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // [7:0] data_byte
   input  logic [0:0]   req_tuser,    // [0] stream_ended
   // verdicts out
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,    // [2:0] status, [34:3] entry_address,
                                      // [66:35] payload_length,
                                      // [98:67] clear_length, [103:99] zero
   // CSR port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic        q_valid;
   item_type    q_item;
   logic        q_pop;
   logic        v_valid;
   logic        v_ready;
   verdict_type v_data;

   logic [31:0] load_ff, load_in;
   logic [31:0] limit_ff, limit_in;
   logic        csr_wr;

   logic        out_valid_ff, out_valid_in;
   verdict_type out_ff, out_in;

   // --- CSRs: write only while idle, so the engine sees them stable (not enforced here) ---
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_LIMIT) ? limit_ff : load_ff;

   always_comb begin
      load_in  = load_ff;
      limit_in = limit_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_LOAD:  load_in  = csr_pwdata;
            REG_LIMIT: limit_in = csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff  <= LOAD_RESET;
         limit_ff <= LIMIT_RESET;
      end else begin
         load_ff  <= load_in;
         limit_ff <= limit_in;
      end
   end

   // --- front: accept and tag beats, short queue ---
   bichc_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // --- back: header checks, CRC, verdicts ---
   bichc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .exp_load   (load_ff),
      .size_limit (limit_ff),
      .v_valid    (v_valid),
      .v_data     (v_data),
      .v_ready    (v_ready)
   );

   // --- output register; engine runs whenever this slot is free or draining ---
   assign v_ready = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (v_valid) begin
         out_valid_in = 1'b1;
         out_in       = v_data;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_ff.clen, out_ff.plen, out_ff.entry, out_ff.status};

   // --- checks ---
   a_entry_only_ok: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status != ST_OK) |-> (out_ff.entry == '0))
      else $error("entry address set on a failing verdict");

   a_lengths_zero_hdr_fail: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.status == ST_SHORT_HDR || out_ff.status == ST_BAD_HDR ||
                        out_ff.status == ST_BAD_LAYOUT))
      |-> (out_ff.plen == '0 && out_ff.clen == '0))
      else $error("lengths set on a header verdict");

   a_no_pop_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !q_pop)
      else $error("engine consumed a beat while the verdict slot was blocked");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.status <= ST_PAY_CRC))
      else $error("verdict status out of range");

endmodule

// ===== test/boot_image_header_and_crc_checker_core_test.sv =====
// ----------------------------------------------------------------------------
// boot_image_header_and_crc_checker_core_test: self-checking bench for the
// boot image checker
// Feeds image files as byte beats: whole good images, images with a broken
// id, header CRC, layout or payload CRC, streams cut short in the header or
// the payload, and random noise. A predictor tracks every accepted beat and
// queues the verdict it expects; a monitor compares each verdict field by
// field. Runs through several CSR settings (reset values, extremes, random)
// and several sender/receiver idle mixes, including a long receiver hold.
// ----------------------------------------------------------------------------
module boot_image_header_and_crc_checker_core_test;
   import bichc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run
   localparam int DRAIN_CYCLES = 4;       // idle margin once every predicted verdict is in
   localparam int HOLD_CYCLES  = 400;     // long receiver hold in the pressure phase

   // shapes of generated image files
   typedef enum {
      SHAPE_GOOD,
      SHAPE_PAY_CRC,
      SHAPE_LAYOUT,
      SHAPE_BAD_ID,
      SHAPE_BAD_HCRC,
      SHAPE_CUT_HDR,
      SHAPE_CUT_PAY,
      SHAPE_NOISE
   } image_shape_type;

   // ------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ------------------------------------------------------------------------
   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata   = 8'd0;   // [7:0] data_byte
   logic [0:0]   req_tuser   = 1'b0;   // [0] stream_ended
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [103:0] rsp_tdata;            // [2:0] status, [34:3] entry_address,
                                       // [66:35] payload_length,
                                       // [98:67] clear_length
   logic         csr_psel    = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite  = 1'b0;
   logic [2:0]   csr_paddr   = 3'd0;
   logic [31:0]  csr_pwdata  = 32'd0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   boot_image_header_and_crc_checker_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // bench state
   // ------------------------------------------------------------------------
   item_type    byte_beats[$];       // beats waiting for the driver
   verdict_type verdicts_due[$];     // predicted verdicts, oldest first

   int unsigned send_idle_pct     = 0;
   int unsigned recv_stall_pct    = 0;
   int unsigned hold_cycles_left  = 0;
   int unsigned cycle_count       = 0;
   int unsigned mismatches        = 0;
   int unsigned beats_queued      = 0;
   int unsigned beats_taken       = 0;
   int unsigned verdicts_checked  = 0;
   int unsigned status_seen[6]    = '{default: 0};

   // CSR mirror, follows every write the bench makes
   logic [31:0] load_setting  = LOAD_RESET;
   logic [31:0] limit_setting = LIMIT_RESET;

   // predictor copy of the image tracker
   phase_type   img_phase = PH_HEADER;
   logic [31:0] img_count = 32'd0;      // byte count within header or payload
   logic [31:0] hdr_word[7] = '{default: 32'd0};
   logic [31:0] crc_reg = CRC_ONES;

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   // reflected CRC-32, one byte, bit-serial
   function automatic logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic void restart_image();
      img_phase = PH_HEADER;
      img_count = 32'd0;
      foreach (hdr_word[k]) hdr_word[k] = 32'd0;
      crc_reg = CRC_ONES;
   endfunction

   function automatic void post_verdict(input status_type st, input logic [31:0] entry,
                                        input logic [31:0] plen, input logic [31:0] clen);
      verdicts_due.push_back('{status: st, entry: entry, plen: plen, clen: clen});
      restart_image();
   endfunction

   // advances the tracker by one accepted beat, queues a verdict when one is due
   function automatic void track_image_byte(input item_type beat);
      logic [4:0]  pos;
      logic [31:0] end_a, ent_a;
      logic        bad;
      if (img_phase == PH_PAYLOAD) begin
         if (beat.kind == KIND_END) begin
            post_verdict(ST_SHORT_PAY, 32'd0, hdr_word[4], hdr_word[5] - hdr_word[4]);
            return;
         end
         crc_reg = crc32_next(crc_reg, beat.data);
         img_count = img_count + 1;
         if (img_count >= hdr_word[4]) begin
            if (~crc_reg == hdr_word[6])
               post_verdict(ST_OK, hdr_word[2] + hdr_word[3], hdr_word[4],
                            hdr_word[5] - hdr_word[4]);
            else
               post_verdict(ST_PAY_CRC, 32'd0, hdr_word[4], hdr_word[5] - hdr_word[4]);
         end
         return;
      end
      // header phase
      if (beat.kind == KIND_END) begin
         post_verdict(ST_SHORT_HDR, 32'd0, 32'd0, 32'd0);
         return;
      end
      pos = img_count[4:0];
      if (pos < HDR_CRC_SPAN) begin
         hdr_word[pos[4:2]][8*pos[1:0] +: 8] = beat.data;
         crc_reg = crc32_next(crc_reg, beat.data);
      end else begin
         // stored header CRC folds into the register; all ones means a match
         crc_reg = crc_reg ^ ({24'd0, beat.data} << (8*pos[1:0]));
      end
      img_count = {27'd0, pos} + 1;
      if (pos != HDR_LAST_POS) return;
      if (hdr_word[0] != IMG_MAGIC || hdr_word[1][15:0] != IMG_VERSION ||
          hdr_word[1][31:16] != IMG_HDR_SIZE || crc_reg != CRC_ONES) begin
         post_verdict(ST_BAD_HDR, 32'd0, 32'd0, 32'd0);
         return;
      end
      end_a = hdr_word[2] + hdr_word[5];
      ent_a = hdr_word[2] + hdr_word[3];
      bad = hdr_word[2] != load_setting || hdr_word[4] == 32'd0 ||
            hdr_word[5] < hdr_word[4] || hdr_word[3] >= hdr_word[4] ||
            hdr_word[5] > limit_setting || end_a < hdr_word[2] ||
            ent_a < hdr_word[2] || ent_a >= end_a;
      if (bad) begin
         post_verdict(ST_BAD_LAYOUT, 32'd0, 32'd0, 32'd0);
         return;
      end
      img_phase = PH_PAYLOAD;
      img_count = 32'd0;
      crc_reg = CRC_ONES;
   endfunction

   // ------------------------------------------------------------------------
   // driver: one beat on offer at a time, random gaps per send_idle_pct
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_image_byte(item_type'({req_tuser[0], req_tdata}));
            beats_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (byte_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               item_type nxt;
               nxt = byte_beats.pop_front();
               req_tdata  <= nxt.data;
               req_tuser  <= nxt.kind;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold, counted down here
   always @(posedge clock) begin
      if (hold_cycles_left != 0) hold_cycles_left <= hold_cycles_left - 1;
   end

   // ------------------------------------------------------------------------
   // monitor: compares each verdict beat with the oldest prediction
   // ------------------------------------------------------------------------
   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("MISMATCH at cycle %0d, %s: got %h, expected %h", cycle_count, what, got, want);
      mismatches++;
   endtask

   task automatic check_verdict();
      verdict_type want;
      if (verdicts_due.size() == 0) begin
         note_mismatch("verdict with none pending", {29'd0, rsp_tdata[2:0]}, 32'd0);
         return;
      end
      want = verdicts_due.pop_front();
      verdicts_checked++;
      status_seen[want.status]++;
      if (rsp_tdata[2:0] != want.status)
         note_mismatch("status", {29'd0, rsp_tdata[2:0]}, {29'd0, want.status});
      if (rsp_tdata[34:3] != want.entry)
         note_mismatch("entry_address", rsp_tdata[34:3], want.entry);
      if (rsp_tdata[66:35] != want.plen)
         note_mismatch("payload_length", rsp_tdata[66:35], want.plen);
      if (rsp_tdata[98:67] != want.clen)
         note_mismatch("clear_length", rsp_tdata[98:67], want.clen);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_verdict();
         rsp_tready <= (hold_cycles_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout: %0d verdicts still pending", verdicts_due.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic void push_beat(input kind_type kind, input logic [7:0] data);
      byte_beats.push_back('{kind: kind, data: data});
      beats_queued++;
   endfunction

   // APB write, then read back; returns on a falling edge
   task automatic program_register(input logic index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);                  // write lands here; read setup follows
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (index == REG_LOAD) load_setting = value;
      else limit_setting = value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata != value) note_mismatch("csr readback", csr_prdata, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // builds one image file of the given shape and queues its beats
   task automatic queue_image(input image_shape_type shape, input int unsigned pay_max);
      logic [31:0] hw[8];
      logic [7:0]  pay[$];
      logic [31:0] room, c;
      int unsigned psz, msz, eoff, spare, n_hdr, cut;
      // largest memory size that neither wraps nor breaks the limit
      room = (~load_setting < limit_setting) ? ~load_setting : limit_setting;
      if (room == 0 && (shape == SHAPE_GOOD || shape == SHAPE_PAY_CRC ||
                        shape == SHAPE_CUT_PAY))
         shape = SHAPE_LAYOUT;
      psz = $urandom_range(1, pay_max);
      if (room != 0 && psz > room) psz = room;
      spare = (room > psz) ? room - psz : 0;
      if (spare > 64) spare = 64;
      msz  = psz + $urandom_range(0, spare);
      eoff = $urandom_range(0, psz - 1);
      c = CRC_ONES;
      repeat (psz) begin
         pay.push_back(8'($urandom));
         c = crc32_next(c, pay[$]);
      end
      hw[0] = IMG_MAGIC;
      hw[1] = {IMG_HDR_SIZE, IMG_VERSION};
      hw[2] = load_setting;
      hw[3] = eoff;
      hw[4] = psz;
      hw[5] = msz;
      hw[6] = ~c;
      case (shape)
         SHAPE_PAY_CRC: hw[6] ^= 32'd1 << $urandom_range(0, 31);
         SHAPE_LAYOUT: begin
            case ($urandom_range(0, 4))
               0: hw[2] ^= 32'd1 << $urandom_range(0, 31);
               1: hw[4] = 32'd0;
               2: hw[5] = hw[4] - 1;
               3: hw[3] = hw[4] + $urandom_range(0, 8);
               default: begin
                  if (limit_setting != CRC_ONES) hw[5] = limit_setting + 1;
                  else if (load_setting != 0) hw[5] = ~load_setting + 1;  // end wraps
                  else hw[3] = hw[4];
               end
            endcase
         end
         SHAPE_BAD_ID: begin
            case ($urandom_range(0, 2))
               0: hw[0] ^= 32'd1 << $urandom_range(0, 31);
               1: hw[1] ^= 32'd1 << $urandom_range(0, 15);
               default: hw[1] ^= 32'd1 << $urandom_range(16, 31);
            endcase
         end
         default: ;
      endcase
      c = CRC_ONES;
      for (int i = 0; i < 28; i++) c = crc32_next(c, hw[i / 4][8 * (i % 4) +: 8]);
      hw[7] = ~c;
      if (shape == SHAPE_BAD_HCRC) hw[7] ^= 32'd1 << $urandom_range(0, 31);
      if (shape == SHAPE_NOISE) foreach (hw[k]) hw[k] = $urandom;

      n_hdr = (shape == SHAPE_CUT_HDR) ? $urandom_range(0, 31) : 32;
      for (int i = 0; i < n_hdr; i++) push_beat(KIND_DATA, hw[i / 4][8 * (i % 4) +: 8]);
      if (shape == SHAPE_CUT_HDR) push_beat(KIND_END, 8'($urandom));
      if (shape == SHAPE_GOOD || shape == SHAPE_PAY_CRC)
         foreach (pay[k]) push_beat(KIND_DATA, pay[k]);
      if (shape == SHAPE_CUT_PAY) begin
         cut = $urandom_range(0, psz - 1);
         for (int i = 0; i < cut; i++) push_beat(KIND_DATA, pay[i]);
         push_beat(KIND_END, 8'($urandom));
      end
   endtask

   // random images until the beat budget is spent; lone_end_pct biases toward
   // bare end-of-stream beats, each an immediate short-header verdict
   task automatic run_random(input int unsigned budget, input int unsigned lone_end_pct);
      int unsigned start, pick, pay_max;
      start = beats_queued;
      while (beats_queued - start < budget) begin
         if ($urandom_range(0, 99) < lone_end_pct) begin
            push_beat(KIND_END, 8'($urandom));
            continue;
         end
         pick    = $urandom_range(0, 99);
         pay_max = ($urandom_range(0, 15) == 0) ? 200 : 24;  // mostly short payloads
         if (pick < 45)      queue_image(SHAPE_GOOD, pay_max);
         else if (pick < 55) queue_image(SHAPE_PAY_CRC, pay_max);
         else if (pick < 65) queue_image(SHAPE_LAYOUT, pay_max);
         else if (pick < 72) queue_image(SHAPE_BAD_ID, pay_max);
         else if (pick < 78) queue_image(SHAPE_BAD_HCRC, pay_max);
         else if (pick < 86) queue_image(SHAPE_CUT_HDR, pay_max);
         else if (pick < 94) queue_image(SHAPE_CUT_PAY, pay_max);
         else                queue_image(SHAPE_NOISE, pay_max);
      end
   endtask

   // sender holds back until every predicted verdict is in and the core is quiet
   task automatic wait_drained();
      do @(negedge clock);
      while (byte_beats.size() != 0 || req_tvalid || verdicts_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset CSR values, no idling: end of stream at byte 0, smallest good image
      push_beat(KIND_END, 8'hff);
      queue_image(SHAPE_GOOD, 1);
      run_random(300, 0);
      wait_drained();

      // random load address, widest limit; sender mostly idle
      send_idle_pct = 78;
      program_register(REG_LOAD, $urandom);
      program_register(REG_LIMIT, 32'hffff_ffff);
      run_random(350, 0);
      wait_drained();

      // load at zero, small random limit; receiver mostly stalled
      send_idle_pct  = 0;
      recv_stall_pct = 78;
      program_register(REG_LOAD, 32'd0);
      program_register(REG_LIMIT, $urandom_range(32'h100, 32'hffff));
      run_random(350, 0);
      wait_drained();

      // load just under the top of the address space: entry and end near wrap
      send_idle_pct  = 36;
      recv_stall_pct = 36;
      program_register(REG_LOAD, 32'hffff_ff00);
      program_register(REG_LIMIT, 32'hffff_ffff);
      run_random(300, 0);
      wait_drained();

      // top load address, zero limit: no layout can pass
      program_register(REG_LOAD, 32'hffff_ffff);
      program_register(REG_LIMIT, 32'd0);
      run_random(150, 0);
      wait_drained();

      // back to reset values; receiver holds off while the sender keeps
      // offering verdict-heavy beats, so the core backs up onto req_tready
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      program_register(REG_LOAD, LOAD_RESET);
      program_register(REG_LIMIT, LIMIT_RESET);
      hold_cycles_left = HOLD_CYCLES;
      run_random(250, 60);
      wait_drained();

      $display("covered %0d byte beats and %0d verdicts over six CSR and idle settings",
               beats_taken, verdicts_checked);
      $display("verdicts: ok %0d, short header %0d, bad header %0d, bad layout %0d, %s %0d, %s %0d",
               status_seen[ST_OK], status_seen[ST_SHORT_HDR], status_seen[ST_BAD_HDR],
               status_seen[ST_BAD_LAYOUT], "short payload", status_seen[ST_SHORT_PAY],
               "payload crc", status_seen[ST_PAY_CRC]);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bichc_pkg.sv
rtl/bichc_front.sv
rtl/bichc_back.sv
rtl/boot_image_header_and_crc_checker_core.sv
test/boot_image_header_and_crc_checker_core_test.sv
